// ===== rtl/core/dpid_pkg.sv =====
// Shared types, widths and codes for the dual encoder PID position controller.
// Used by the channel interfaces, the controller, the datapath and the divider.
// No dependencies.

package dpid_pkg;

    // Field widths fixed by the item and result formats.
    localparam int TGT_WIDTH       = 32;
    localparam int DT_WIDTH        = 24;
    localparam int GAIN_WIDTH      = 16;
    localparam int POWER_WIDTH     = 8;
    localparam int FRAC_BITS       = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // Internal arithmetic widths.
    localparam int ERR_WIDTH   = 33;
    localparam int DIFF_WIDTH  = 34;
    localparam int SUM_WIDTH   = 48;
    localparam int SPROD_WIDTH = 58;
    localparam int GOP_WIDTH   = 55;
    localparam int GPROD_WIDTH = GOP_WIDTH + GAIN_WIDTH + 1;
    localparam int ACC_WIDTH   = 53;

    // Shared divider: 64-bit dividend, two quotient bits per cycle.
    localparam int DIV_WIDTH      = 64;
    localparam int DIV_RADIX_BITS = 2;

    localparam logic [DT_WIDTH-1:0] MICRO = 24'd1000000;
    localparam int DTERM_LIMIT_LOG2 = 50;

    // Configuration register indexes.
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    localparam cfg_index_t REG_KP = 2'd0;
    localparam cfg_index_t REG_KI = 2'd1;
    localparam cfg_index_t REG_KD = 2'd2;

    // Gain multiplier operand select.
    typedef logic [1:0] gain_sel_t;
    localparam gain_sel_t GAIN_KP = 2'd0;
    localparam gain_sel_t GAIN_KI = 2'd1;
    localparam gain_sel_t GAIN_KD = 2'd2;

    // Divider operand select.
    typedef logic div_sel_t;
    localparam div_sel_t DIV_DERIV = 1'b0;
    localparam div_sel_t DIV_INTEG = 1'b1;

    // Accumulator operations.
    typedef logic [1:0] acc_op_t;
    localparam acc_op_t ACC_NONE   = 2'd0;
    localparam acc_op_t ACC_LOAD_P = 2'd1;
    localparam acc_op_t ACC_ADD_D  = 2'd2;
    localparam acc_op_t ACC_ADD_Q  = 2'd3;

    typedef struct packed {
        logic                        command;
        logic                        enc_a_one;
        logic                        enc_b_one;
        logic                        enc_a_two;
        logic                        enc_b_two;
        logic signed [TGT_WIDTH-1:0] target_one;
        logic signed [TGT_WIDTH-1:0] target_two;
        logic [DT_WIDTH-1:0]         elapsed_us;
    } dpid_item_t;

    typedef struct packed {
        logic [POWER_WIDTH-1:0] power_one;
        logic                   forward_one;
        logic [POWER_WIDTH-1:0] power_two;
        logic                   forward_two;
    } dpid_result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      motor;
        logic      edge_step;
        logic      capture;
        logic      load_err;
        logic      load_edt;
        logic      update_sum;
        gain_sel_t gain_sel;
        logic      load_gprod;
        logic      div_start;
        div_sel_t  div_sel;
        acc_op_t   acc_op;
        logic      load_res;
        logic      load_out;
    } dpid_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
    } dpid_stat_t;

endpackage

// ===== rtl/core/dpid_channels.sv =====
// Valid/ready channel interfaces for items and results.
// Depends on dpid_pkg for the payload types.

interface dpid_item_if
    import dpid_pkg::*;
;
    logic       valid;
    logic       ready;
    dpid_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dpid_result_if
    import dpid_pkg::*;
;
    logic         valid;
    logic         ready;
    dpid_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/dpid_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle, shared by the
// derivative and integral terms. Depends on dpid_pkg.

module dpid_div
    import dpid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_WIDTH-1:0] dividend,
    input  logic [DT_WIDTH-1:0]  divisor,
    output logic [DIV_WIDTH-1:0] quotient,
    output logic                 done
);

    localparam int ITERS     = DIV_WIDTH / DIV_RADIX_BITS;
    localparam int CNT_WIDTH = $clog2(ITERS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [DT_WIDTH-1:0]  den_reg;
    logic [DT_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIV_WIDTH-1:0] quo_reg, quo_next;

    logic [DT_WIDTH:0]    trial;
    logic [DT_WIDTH-1:0]  step_rem;
    logic [DIV_WIDTH-1:0] step_quo;

    // Two restoring steps per cycle. The remainder stays below the divisor.
    always_comb
    begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial    = {step_rem, step_quo[DIV_WIDTH-1]};
            step_quo = {step_quo[DIV_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                step_rem    = DT_WIDTH'(trial - {1'b0, den_reg});
                step_quo[0] = 1'b1;
            end
            else
            begin
                step_rem = trial[DT_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(ITERS - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/dpid_datapath.sv =====
// Datapath: gains, encoder counters, PID state, the two multipliers, the
// accumulator, the result registers and the shared divider.
// Depends on dpid_pkg and dpid_div.

module dpid_datapath
    import dpid_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dpid_cmd_t                  cmd,
    input  dpid_item_t                 item,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [GAIN_WIDTH-1:0]      cfg_data,
    output dpid_stat_t                 stat,
    output dpid_result_t               result
);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic [GPROD_WIDTH-1:0] DTERM_LIMIT = GPROD_WIDTH'(1) << DTERM_LIMIT_LOG2;

    logic [GAIN_WIDTH-1:0] kp_reg, ki_reg, kd_reg;

    logic [COUNT_WIDTH-1:0]       pos_one_reg, pos_two_reg;
    logic [COUNT_WIDTH-1:0]       pos_one_next, pos_two_next;
    logic signed [ERR_WIDTH-1:0]  last_one_reg, last_two_reg;
    logic signed [SUM_WIDTH-1:0]  sum_one_reg, sum_two_reg;

    logic signed [TGT_WIDTH-1:0]  tgt_one_reg, tgt_two_reg;
    logic [DT_WIDTH-1:0]          dt_reg;
    logic signed [ERR_WIDTH-1:0]  err_reg, err_next;
    logic signed [SPROD_WIDTH-1:0] sprod_reg, sprod_next;
    logic signed [GPROD_WIDTH-1:0] gprod_reg, gprod_next;
    logic signed [ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic                         div_neg_reg, div_neg_next;

    logic [POWER_WIDTH-1:0] power_one_reg, power_two_reg, power_next;
    logic                   forward_one_reg, forward_two_reg, forward_next;
    dpid_result_t           out_reg;

    // Per-motor selection.
    logic [COUNT_WIDTH-1:0]      cur_pos;
    logic signed [ERR_WIDTH-1:0] cur_last;
    logic signed [SUM_WIDTH-1:0] cur_sum;
    logic signed [TGT_WIDTH-1:0] cur_tgt;

    // Multipliers and helpers.
    logic signed [DIFF_WIDTH-1:0]          scale_a;
    logic signed [DT_WIDTH:0]              scale_b;
    logic signed [DIFF_WIDTH+DT_WIDTH:0]   scale_prod;
    logic signed [SPROD_WIDTH:0]           sum_wide;
    logic signed [SUM_WIDTH-1:0]           sum_sat;
    logic signed [GOP_WIDTH-1:0]           gain_a;
    logic [GAIN_WIDTH-1:0]                 gain_b;
    logic signed [GPROD_WIDTH-1:0]         gain_prod;

    logic [DIV_WIDTH-1:0]          div_dividend;
    logic [DT_WIDTH-1:0]           div_divisor;
    logic [DIV_WIDTH-1:0]          div_q;
    logic signed [SPROD_WIDTH-1:0] sprod_mag;
    logic signed [GPROD_WIDTH-1:0] gprod_mag;

    logic [GPROD_WIDTH-1:0]       dclamp;
    logic signed [ACC_WIDTH-1:0]  dterm_mag, dterm, qterm_mag, qterm;
    logic [ACC_WIDTH-1:0]         acc_mag;

    assign cur_pos  = cmd.motor ? pos_two_reg  : pos_one_reg;
    assign cur_last = cmd.motor ? last_two_reg : last_one_reg;
    assign cur_sum  = cmd.motor ? sum_two_reg  : sum_one_reg;
    assign cur_tgt  = cmd.motor ? tgt_two_reg  : tgt_one_reg;

    // Encoder steps: up one when A and B differ, down one otherwise.
    assign pos_one_next = pos_one_reg + ((item.enc_a_one != item.enc_b_one)
                                         ? COUNT_WIDTH'(1) : {COUNT_WIDTH{1'b1}});
    assign pos_two_next = pos_two_reg + ((item.enc_a_two != item.enc_b_two)
                                         ? COUNT_WIDTH'(1) : {COUNT_WIDTH{1'b1}});

    assign err_next = ERR_WIDTH'(cur_tgt) - ERR_WIDTH'($signed(cur_pos));

    // Scale multiplier: error times elapsed time, or error change times 1e6.
    always_comb
    begin
        if (cmd.update_sum)
        begin
            scale_a = DIFF_WIDTH'(err_reg) - DIFF_WIDTH'(cur_last);
            scale_b = $signed({1'b0, MICRO});
        end
        else
        begin
            scale_a = DIFF_WIDTH'(err_reg);
            scale_b = $signed({1'b0, dt_reg});
        end
        scale_prod = scale_a * scale_b;
        sprod_next = SPROD_WIDTH'(scale_prod);
    end

    // Integral update with saturation to 48 bits.
    always_comb
    begin
        sum_wide = (SPROD_WIDTH+1)'(cur_sum) + (SPROD_WIDTH+1)'(sprod_reg);
        if (sum_wide > (SPROD_WIDTH+1)'(SUM_MAX))
        begin
            sum_sat = SUM_MAX;
        end
        else if (sum_wide < (SPROD_WIDTH+1)'(SUM_MIN))
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = SUM_WIDTH'(sum_wide);
        end
    end

    // Gain multiplier: a gain times the error, the integral or |derivative|.
    always_comb
    begin
        unique case (cmd.gain_sel)
            GAIN_KP:
            begin
                gain_a = GOP_WIDTH'(err_reg);
                gain_b = kp_reg;
            end
            GAIN_KI:
            begin
                gain_a = GOP_WIDTH'(cur_sum);
                gain_b = ki_reg;
            end
            GAIN_KD:
            begin
                gain_a = $signed({1'b0, div_q[GOP_WIDTH-2:0]});
                gain_b = kd_reg;
            end
            default:
            begin
                gain_a = '0;
                gain_b = '0;
            end
        endcase
        gain_prod  = gain_a * $signed({1'b0, gain_b});
        gprod_next = gain_prod;
    end

    // Divider operands: magnitudes in, sign kept aside for truncation to zero.
    always_comb
    begin
        sprod_mag = sprod_reg[SPROD_WIDTH-1] ? -sprod_reg : sprod_reg;
        gprod_mag = gprod_reg[GPROD_WIDTH-1] ? -gprod_reg : gprod_reg;
        unique case (cmd.div_sel)
            DIV_DERIV:
            begin
                div_dividend = DIV_WIDTH'($unsigned(sprod_mag));
                div_divisor  = dt_reg;
                div_neg_next = sprod_reg[SPROD_WIDTH-1];
            end
            DIV_INTEG:
            begin
                div_dividend = gprod_mag[DIV_WIDTH-1:0];
                div_divisor  = MICRO;
                div_neg_next = gprod_reg[GPROD_WIDTH-1];
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = MICRO;
                div_neg_next = 1'b0;
            end
        endcase
    end

    // Derivative term is clamped to at most 2^50 in magnitude.
    always_comb
    begin
        dclamp    = ($unsigned(gprod_reg) > DTERM_LIMIT) ? DTERM_LIMIT : $unsigned(gprod_reg);
        dterm_mag = $signed(ACC_WIDTH'(dclamp));
        dterm     = div_neg_reg ? -dterm_mag : dterm_mag;
        qterm_mag = $signed(ACC_WIDTH'(div_q));
        qterm     = div_neg_reg ? -qterm_mag : qterm_mag;
    end

    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_NONE:   acc_next = acc_reg;
            ACC_LOAD_P: acc_next = ACC_WIDTH'(gprod_reg);
            ACC_ADD_D:  acc_next = acc_reg + dterm;
            ACC_ADD_Q:  acc_next = acc_reg + qterm;
            default:    acc_next = acc_reg;
        endcase
    end

    // Drive power is the magnitude in whole units, saturated.
    always_comb
    begin
        acc_mag      = acc_reg[ACC_WIDTH-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
        power_next   = (|acc_mag[ACC_WIDTH-1:POWER_WIDTH+FRAC_BITS])
                       ? {POWER_WIDTH{1'b1}}
                       : acc_mag[POWER_WIDTH+FRAC_BITS-1:FRAC_BITS];
        forward_next = ~acc_reg[ACC_WIDTH-1];
    end

    // Gains, counters and PID state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= GAIN_WIDTH'(256);
            ki_reg       <= '0;
            kd_reg       <= '0;
            pos_one_reg  <= '0;
            pos_two_reg  <= '0;
            last_one_reg <= '0;
            last_two_reg <= '0;
            sum_one_reg  <= '0;
            sum_two_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KP:  kp_reg <= cfg_data;
                    REG_KI:  ki_reg <= cfg_data;
                    REG_KD:  kd_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.edge_step)
            begin
                pos_one_reg <= pos_one_next;
                pos_two_reg <= pos_two_next;
            end
            if (cmd.update_sum)
            begin
                if (cmd.motor)
                begin
                    sum_two_reg  <= sum_sat;
                    last_two_reg <= err_reg;
                end
                else
                begin
                    sum_one_reg  <= sum_sat;
                    last_one_reg <= err_reg;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_one_reg <= item.target_one;
            tgt_two_reg <= item.target_two;
            dt_reg      <= (item.elapsed_us == '0) ? DT_WIDTH'(1) : item.elapsed_us;
        end
        if (cmd.load_err)
        begin
            err_reg <= err_next;
        end
        if (cmd.load_edt || cmd.update_sum)
        begin
            sprod_reg <= sprod_next;
        end
        if (cmd.load_gprod)
        begin
            gprod_reg <= gprod_next;
        end
        if (cmd.div_start)
        begin
            div_neg_reg <= div_neg_next;
        end
        acc_reg <= acc_next;
        if (cmd.load_res)
        begin
            if (cmd.motor)
            begin
                power_two_reg   <= power_next;
                forward_two_reg <= forward_next;
            end
            else
            begin
                power_one_reg   <= power_next;
                forward_one_reg <= forward_next;
            end
        end
        if (cmd.load_out)
        begin
            out_reg.power_one   <= power_one_reg;
            out_reg.forward_one <= forward_one_reg;
            out_reg.power_two   <= power_two_reg;
            out_reg.forward_two <= forward_two_reg;
        end
    end

    dpid_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (stat.div_done)
    );

    assign result = out_reg;

endmodule

// ===== rtl/core/dpid_ctrl.sv =====
// Controller: accepts items, sequences the per-motor PID computation and
// owns the result valid flag. Depends on dpid_pkg.

module dpid_ctrl
    import dpid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_command,
    output logic       item_ready,
    input  logic       result_ready,
    output logic       result_valid,
    input  dpid_stat_t stat,
    output dpid_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ERR    = 4'd1;
    localparam logic [3:0] ST_EDT    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_PMUL   = 4'd4;
    localparam logic [3:0] ST_DSTART = 4'd5;
    localparam logic [3:0] ST_DWAIT  = 4'd6;
    localparam logic [3:0] ST_DMUL   = 4'd7;
    localparam logic [3:0] ST_DACC   = 4'd8;
    localparam logic [3:0] ST_IMUL   = 4'd9;
    localparam logic [3:0] ST_ISTART = 4'd10;
    localparam logic [3:0] ST_IWAIT  = 4'd11;
    localparam logic [3:0] ST_IACC   = 4'd12;
    localparam logic [3:0] ST_RES    = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       motor_reg, motor_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        motor_next     = motor_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.motor      = motor_reg;
        item_ready     = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_command)
                    begin
                        cmd.capture = 1'b1;
                        motor_next  = 1'b0;
                        state_next  = ST_ERR;
                    end
                    else
                    begin
                        cmd.edge_step = 1'b1;
                    end
                end
            end
            ST_ERR:
            begin
                cmd.load_err = 1'b1;
                state_next   = ST_EDT;
            end
            ST_EDT:
            begin
                cmd.load_edt = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.update_sum = 1'b1;
                state_next     = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.gain_sel   = GAIN_KP;
                cmd.load_gprod = 1'b1;
                state_next     = ST_DSTART;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DERIV;
                cmd.acc_op    = ACC_LOAD_P;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL:
            begin
                cmd.gain_sel   = GAIN_KD;
                cmd.load_gprod = 1'b1;
                state_next     = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.acc_op = ACC_ADD_D;
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.gain_sel   = GAIN_KI;
                cmd.load_gprod = 1'b1;
                state_next     = ST_ISTART;
            end
            ST_ISTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INTEG;
                state_next    = ST_IWAIT;
            end
            ST_IWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_IACC;
                end
            end
            ST_IACC:
            begin
                cmd.acc_op = ACC_ADD_Q;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                cmd.load_res = 1'b1;
                if (motor_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    motor_next = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            motor_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            motor_reg     <= motor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/core/dual_encoder_pid_position_control.sv =====
// Top level of the dual encoder PID position controller.
// Depends on dpid_pkg, the channel interfaces, dpid_ctrl and dpid_datapath.

// The block keeps two wrapping encoder counters and runs a PID loop for two
// motors. An item with command 0 is an encoder edge: each counter steps up
// by one when its A and B levels differ and down by one when they match; the
// transfer produces no result. An item with command 1 is a control tick
// carrying two targets and the elapsed time in microseconds (zero counts as
// one). It produces exactly one result transfer holding the direction and
// the drive power (control value over 256, saturated at 255) for each motor.
// Gains are unsigned Q8.8 and are written through the plain write port
// (index 0 proportional, 1 integral, 2 derivative; other indexes are
// ignored). The user must write them only while the block is idle; the
// block itself does not enforce this. For a control tick each motor needs
// two divisions on the one shared divider, which retires two quotient bits
// per cycle, besides the multiplies and the accumulation. Items are taken
// one at a time; the result sits in an output register, so the next item is
// accepted while it waits to be taken.

module dual_encoder_pid_position_control
    import dpid_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    dpid_item_if.sink                  item,
    dpid_result_if.source              result,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [GAIN_WIDTH-1:0]      cfg_data
);

    dpid_cmd_t  cmd;
    dpid_stat_t stat;

    // The controller decides when items transfer and steps the datapath
    // through both motors' computations.
    dpid_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_command (item.payload.command),
        .item_ready   (item.ready),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    // The datapath holds all arithmetic, the PID and encoder state and the result register.
    dpid_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item.payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result.payload)
    );

endmodule

// ===== tb/dual_encoder_pid_position_control_test.sv =====
// Self-checking testbench for dual_encoder_pid_position_control. A short directed run
// covers the special cases, then random encoder edges and control ticks run under five gains.
// Depends on dpid_pkg, the channel interfaces in dpid_channels.sv and the RTL top level.

module dual_encoder_pid_position_control_test;
    import dpid_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 525;
    localparam int GAIN_PHASES   = 5;
    // Settling time that covers any work still in flight.
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 3000;
    localparam longint RUN_LIMIT = 1000000;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    // The index port is two bits wide; this code selects no register.
    localparam cfg_index_t REG_UNUSED = 2'd3;

    localparam longint MICROS_PER_SECOND = 1000000;
    localparam longint DTERM_CAP = longint'(1) <<< 50;
    localparam longint SUM_MAX   = (longint'(1) <<< 47) - 1;
    localparam longint SUM_MIN   = -(longint'(1) <<< 47);

    localparam logic [GAIN_WIDTH-1:0]       GAIN_ONE    = 16'd256;
    localparam logic [GAIN_WIDTH-1:0]       GAIN_MAX    = 16'hFFFF;
    localparam logic signed [TGT_WIDTH-1:0] TARGET_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [TGT_WIDTH-1:0] TARGET_MIN  = 32'sh80000000;
    localparam logic [DT_WIDTH-1:0]         ELAPSED_MAX = '1;

    // The scoreboard mirrors the gains, both encoder counters and the PID state
    // of each motor. Every accepted control tick pushes one predicted drive
    // result; every result transfer is checked against the oldest of them.
    class drive_scoreboard;
        logic [GAIN_WIDTH-1:0] kp;
        logic [GAIN_WIDTH-1:0] ki;
        logic [GAIN_WIDTH-1:0] kd;
        logic [31:0]           position_one;
        logic [31:0]           position_two;
        longint                last_error_one;
        longint                last_error_two;
        longint                error_sum_one;
        longint                error_sum_two;
        dpid_result_t          expected_drives[$];
        int                    mismatches;
        int                    edge_count;
        int                    tick_count;
        int                    result_count;

        function new();
            kp = GAIN_ONE;
            ki = '0;
            kd = '0;
            position_one = '0;
            position_two = '0;
            last_error_one = 0;
            last_error_two = 0;
            error_sum_one = 0;
            error_sum_two = 0;
            mismatches = 0;
            edge_count = 0;
            tick_count = 0;
            result_count = 0;
        endfunction

        function void write_gain(cfg_index_t index, logic [GAIN_WIDTH-1:0] value);
            case (index)
                REG_KP:  kp = value;
                REG_KI:  ki = value;
                REG_KD:  kd = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function logic [31:0] step_count(logic [31:0] count, logic a, logic b);
            return (a != b) ? count + 32'd1 : count - 32'd1;
        endfunction

        // One motor's PID update: error, saturating integral, derivative with
        // its term clamped, then the Q8.8 control value reduced to a direction
        // and a power that saturates at 255.
        function void predict_motor_drive(input logic signed [31:0] target,
                                          input logic [31:0] count, input longint dt,
                                          inout longint last_error, inout longint error_sum,
                                          output logic [7:0] power, output logic forward);
            longint err;
            longint slope;
            longint dterm;
            longint total;
            longint mag;
            longint p_gain;
            longint i_gain;
            longint d_gain;
            p_gain = longint'(kp);
            i_gain = longint'(ki);
            d_gain = longint'(kd);
            err = longint'(target) - longint'($signed(count));
            error_sum = error_sum + err * dt;
            if (error_sum > SUM_MAX)
                error_sum = SUM_MAX;
            if (error_sum < SUM_MIN)
                error_sum = SUM_MIN;
            slope = ((err - last_error) * MICROS_PER_SECOND) / dt;
            mag = (slope < 0) ? -slope : slope;
            if (d_gain != 0 && mag > DTERM_CAP / d_gain)
                dterm = (slope < 0) ? -DTERM_CAP : DTERM_CAP;
            else
                dterm = d_gain * slope;
            total = p_gain * err + (i_gain * error_sum) / MICROS_PER_SECOND + dterm;
            last_error = err;
            mag = (total < 0) ? -total : total;
            mag = mag >>> FRAC_BITS;
            if (mag > 255)
                mag = 255;
            power = mag[7:0];
            forward = (total >= 0);
        endfunction

        function void note_item(dpid_item_t it);
            dpid_result_t drive;
            longint       dt;
            logic [7:0]   power_a;
            logic [7:0]   power_b;
            logic         forward_a;
            logic         forward_b;
            if (it.command == CMD_EDGE) begin
                position_one = step_count(position_one, it.enc_a_one, it.enc_b_one);
                position_two = step_count(position_two, it.enc_a_two, it.enc_b_two);
                edge_count++;
            end
            else begin
                dt = (it.elapsed_us == '0) ? 1 : longint'(it.elapsed_us);
                predict_motor_drive(it.target_one, position_one, dt, last_error_one,
                                    error_sum_one, power_a, forward_a);
                predict_motor_drive(it.target_two, position_two, dt, last_error_two,
                                    error_sum_two, power_b, forward_b);
                drive.power_one = power_a;
                drive.forward_one = forward_a;
                drive.power_two = power_b;
                drive.forward_two = forward_b;
                expected_drives.push_back(drive);
                tick_count++;
            end
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                     result_count, what, got, want);
            mismatches++;
        endtask

        task check_result(dpid_result_t got);
            dpid_result_t want;
            result_count++;
            if (expected_drives.size() == 0) begin
                report_mismatch("unexpected result, power_one", got.power_one, 8'd0);
                return;
            end
            want = expected_drives.pop_front();
            if (got.power_one !== want.power_one)
                report_mismatch("power_one", got.power_one, want.power_one);
            if (got.forward_one !== want.forward_one)
                report_mismatch("forward_one", got.forward_one, want.forward_one);
            if (got.power_two !== want.power_two)
                report_mismatch("power_two", got.power_two, want.power_two);
            if (got.forward_two !== want.forward_two)
                report_mismatch("forward_two", got.forward_two, want.forward_two);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [GAIN_WIDTH-1:0] cfg_data;

    dpid_item_if   item_ch();
    dpid_result_if result_ch();

    drive_scoreboard sb;
    bit              hold_request = 1'b0;
    int              burst_left = 0;
    int              gain_settings = 0;
    longint          cycle_count = 0;

    dual_encoder_pid_position_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Reset is applied once and released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Both channels are sampled on the rising edge; a transfer happens when
    // valid and ready are both high there.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                sb.note_item(item_ch.payload);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                sb.check_result(result_ch.payload);
        end
    end

    // Watchdog: a run that never drains ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver. It moves through stretches of different behavior:
    // always ready, coin-flip ready, a fixed rotating ready mask, and mostly
    // stalled. A hold request from the stimulus makes it refuse results for a
    // long stretch, which it counts down itself.
    initial
    begin
        int         mode;
        int         stretch;
        int         hold_left;
        int         mask_bit;
        logic [7:0] ready_mask;
        stretch = 0;
        hold_left = 0;
        mask_bit = 0;
        mode = 0;
        ready_mask = 8'hFF;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (stretch == 0) begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(40, 160);
                ready_mask = 8'($urandom_range(1, 255));
            end
            stretch--;
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 1) != 0);
                    2: begin
                        result_ch.ready <= ready_mask[mask_bit];
                        mask_bit = (mask_bit + 1) % 8;
                    end
                    default: result_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offers one item from a falling edge and returns on the falling edge
    // after its transfer. Valid stays high so the next item can follow at once.
    task automatic send_item(input dpid_item_t it);
        item_ch.payload <= it;
        item_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            item_ch.valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // The sender works in bursts of random length separated by random gaps;
    // about a quarter of the bursts follow the previous one with no gap.
    task automatic offer_item(input dpid_item_t it);
        if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_item(it);
    endtask

    // Stops offering items until every predicted drive result has come back,
    // then lets the block settle so it is idle for a register write.
    task automatic wait_for_drives();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one register. The write enable is left high so writes can follow
    // back to back; load_gains lowers it after the last one.
    task automatic write_register(input cfg_index_t index, input logic [GAIN_WIDTH-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.write_gain(index, value);
        @(negedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_WIDTH-1:0] p_gain,
                              input logic [GAIN_WIDTH-1:0] i_gain,
                              input logic [GAIN_WIDTH-1:0] d_gain);
        write_register(REG_KP, p_gain);
        write_register(REG_KI, i_gain);
        write_register(REG_KD, d_gain);
        cfg_we <= 1'b0;
        gain_settings++;
    endtask

    // Encoder levels are don't-care on a tick, and targets and elapsed time on
    // an edge, so those fields carry random bits.
    function automatic dpid_item_t make_tick(input logic signed [TGT_WIDTH-1:0] target_a,
                                             input logic signed [TGT_WIDTH-1:0] target_b,
                                             input logic [DT_WIDTH-1:0] elapsed);
        dpid_item_t it;
        it.command = CMD_TICK;
        {it.enc_a_one, it.enc_b_one, it.enc_a_two, it.enc_b_two} = 4'($urandom);
        it.target_one = target_a;
        it.target_two = target_b;
        it.elapsed_us = elapsed;
        return it;
    endfunction

    function automatic dpid_item_t make_edge(input logic a1, input logic b1,
                                             input logic a2, input logic b2);
        dpid_item_t it;
        it.command = CMD_EDGE;
        it.enc_a_one = a1;
        it.enc_b_one = b1;
        it.enc_a_two = a2;
        it.enc_b_two = b2;
        it.target_one = $urandom;
        it.target_two = $urandom;
        it.elapsed_us = DT_WIDTH'($urandom);
        return it;
    endfunction

    // Most targets sit close to the current position so the power does not
    // always saturate; the rest are full-range or extreme.
    function automatic logic signed [TGT_WIDTH-1:0] pick_target(input logic [31:0] count);
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return TARGET_MAX;
                    1: return TARGET_MIN;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $signed(count) + (int'($urandom_range(0, 800)) - 400);
        endcase
    endfunction

    function automatic logic [DT_WIDTH-1:0] pick_elapsed();
        case ($urandom_range(0, 7))
            0, 1: return DT_WIDTH'($urandom);
            2: return ($urandom_range(0, 1) != 0) ? ELAPSED_MAX : '0;
            default: return DT_WIDTH'($urandom_range(1, 5000));
        endcase
    endfunction

    initial
    begin
        int   sent;
        int   run;
        bit   dir1;
        bit   dir2;
        logic a1;
        logic b1;
        logic a2;
        logic b2;
        bit   hold_done;
        hold_done = 1'b0;
        sb = new();
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        cfg_we = 1'b0;
        cfg_index = REG_KP;
        cfg_data = '0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Directed part under the reset gains (kp = 1.0, ki = kd = 0).
        // A tick at rest with zero elapsed time must act as one microsecond.
        offer_item(make_tick(0, 0, '0));
        // All four level pairs for each encoder; the counters end at +1 and -1.
        offer_item(make_edge(1'b0, 1'b0, 1'b1, 1'b0));
        offer_item(make_edge(1'b0, 1'b1, 1'b1, 1'b1));
        offer_item(make_edge(1'b1, 1'b0, 1'b0, 1'b0));
        offer_item(make_edge(1'b1, 1'b1, 1'b0, 1'b1));
        offer_item(make_edge(1'b1, 1'b0, 1'b1, 1'b1));
        // Small errors give an unsaturated power in both directions; errors of 301 saturate it.
        offer_item(make_tick(6, -6, 24'd1));
        offer_item(make_tick(-300, 300, 24'd1000));
        // Extreme targets and elapsed times.
        offer_item(make_tick(TARGET_MAX, TARGET_MIN, ELAPSED_MAX));
        offer_item(make_tick(TARGET_MIN, TARGET_MAX, '0));
        wait_for_drives();

        // Integral alone at full gain: the first ticks drive each integral
        // into its limit, and the reversal lands near zero only
        // because of that limit.
        load_gains(0, GAIN_MAX, 0);
        offer_item(make_tick(TARGET_MAX, TARGET_MIN, ELAPSED_MAX));
        offer_item(make_tick(TARGET_MAX, TARGET_MIN, ELAPSED_MAX));
        offer_item(make_tick(TARGET_MIN, TARGET_MAX, 24'd65536));
        offer_item(make_tick(0, 0, 24'd1));
        wait_for_drives();

        // Derivative alone at full gain: full-scale error swings over one
        // microsecond hit the clamp on the derivative term in both directions.
        // A write to the unused index must leave every gain alone.
        write_register(REG_UNUSED, 16'($urandom));
        load_gains(0, 0, GAIN_MAX);
        offer_item(make_tick(TARGET_MAX, TARGET_MIN, '0));
        offer_item(make_tick(TARGET_MIN, TARGET_MAX, 24'd1));
        offer_item(make_tick(2, -2, 24'd1000));
        wait_for_drives();

        // Random part: runs of encoder edges that mostly move each counter in
        // one direction, separated by control ticks, under several gain sets.
        for (int phase = 0; phase < GAIN_PHASES; phase++) begin
            case (phase)
                0: load_gains(0, 0, 0);
                1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
                2: load_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 4096)),
                              16'($urandom_range(0, 64)));
                3: load_gains(16'($urandom), 16'($urandom), 16'($urandom));
                default: load_gains(GAIN_ONE, 16'd500, 16'd4);
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / GAIN_PHASES) begin
                // Once, the receiver refuses results for a long stretch while
                // items keep coming, so the block backs up and stalls its input.
                if (phase == 2 && !hold_done && sent >= 20) begin
                    hold_request = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 1) != 0) begin
                    offer_item(make_tick(pick_target(sb.position_one),
                                         pick_target(sb.position_two), pick_elapsed()));
                    sent++;
                end
                else begin
                    run = $urandom_range(1, 6);
                    dir1 = $urandom_range(0, 1);
                    dir2 = $urandom_range(0, 1);
                    repeat (run) begin
                        a1 = $urandom_range(0, 1);
                        a2 = $urandom_range(0, 1);
                        if ($urandom_range(0, 3) == 0) begin
                            b1 = $urandom_range(0, 1);
                            b2 = $urandom_range(0, 1);
                        end
                        else begin
                            b1 = dir1 ? !a1 : a1;
                            b2 = dir2 ? !a2 : a2;
                        end
                        offer_item(make_edge(a1, b1, a2, b2));
                        sent++;
                    end
                end
            end
            wait_for_drives();
        end

        $display("Covered %0d encoder edges and %0d control ticks, %0d results checked,",
                 sb.edge_count, sb.tick_count, sb.result_count);
        $display("over %0d gain settings plus reset gains, with a %0d-cycle output stall.",
                 gain_settings, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
